// ===== rtl/core/tcpi_pkg.sv =====
// ----------------------------------------------------------------------------
// tcpi_pkg - shared types and constants for the palette indexer
// Token handed from cell to cell along the palette chain, field widths and
// the byte-reverse helper.
// ----------------------------------------------------------------------------
package tcpi_pkg;

   // color_index is 8 bits, so at most this many entries are usable
   localparam int INDEX_SPAN = 256;
   localparam int PIX_W      = 32;
   localparam int IDX_W      = 8;

   // pixel token walking down the chain of cells
   typedef struct packed {
      logic             valid;
      logic [PIX_W-1:0] pix;
   } token_type;

   // one finished result
   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic             is_new;
      logic [PIX_W-1:0] word;
      logic             ovf;
   } result_type;

   function automatic logic [PIX_W-1:0] swap_byte_order(input logic [PIX_W-1:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

// ===== rtl/core/tcpi_cell.sv =====
// ----------------------------------------------------------------------------
// tcpi_cell - one palette entry of the chain
// Holds one palette word. Compares the token it holds against that word,
// claims a hit, stores the pixel when it is the next free slot, or hands
// the token to the next cell.
// ----------------------------------------------------------------------------
module tcpi_cell
   import tcpi_pkg::*;
#(
   parameter int K  = 0,   // position of this cell in the chain
   parameter int PW = 9    // width of the fill count
) (
   input  logic          clock,
   input  logic          reset,
   input  token_type     tok_i,
   input  logic [PW-1:0] used_i,
   output token_type     tok_o,
   output logic          hit_o,
   output logic [PIX_W-1:0] entry_o
);

   token_type        tok_ff;
   logic [PIX_W-1:0] entry_ff;
   logic             in_use;
   logic             match;
   logic             fill;

   // token register, one hop per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_i.valid;
      end
      tok_ff.pix <= tok_i.pix;
   end

   // compare against the stored word; only entries below the fill count count
   assign in_use = used_i > PW'(K);
   assign match  = entry_ff == tok_ff.pix;
   assign fill   = tok_ff.valid && (used_i == PW'(K));
   assign hit_o  = tok_ff.valid && in_use && match;

   // miss in this cell: pass on
   assign tok_o.valid = tok_ff.valid && in_use && !match;
   assign tok_o.pix   = tok_ff.pix;

   // first free slot takes the pixel
   always_ff @(posedge clock) begin
      if (fill) begin
         entry_ff <= tok_ff.pix;
      end
   end

   assign entry_o = entry_ff;

endmodule

// ===== rtl/core/true_color_palette_indexer.sv =====
// ----------------------------------------------------------------------------
// true_color_palette_indexer - exact-match palette builder
// Maps 32-bit pixel words to 8-bit palette indices, appending unseen words
// to the palette and flagging overflow when the palette is full.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata / data             | tuser
//  --------+-----------+--------------------------+-----------------------
//  req_    | in        | pixel_value[31:0]        | first_of_image
//  rsp_    | out       | color_index, entry_value | is_new, overflow
//  csr_    | in        | byte_swap                | -
//
//  A pixel's result is produced once its token reaches the matching or newly
//  filled entry, or once it falls off the last cell on overflow; the token
//  walks the chain of palette cells one cell per cycle.
//  One pixel is in flight at a time; the next transfer is taken once the
//  walk is done and the skid register is empty.
//  Reset clears the fill count and the control state; palette words are
//  not cleared, the fill count marks which are valid.
//  A stalled result sink holds the result; one more result can be parked.
// ----------------------------------------------------------------------------
module true_color_palette_indexer
   import tcpi_pkg::*;
#(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] pixel_value
   input  logic        req_tuser,   // [0] first_of_image
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] color_index, [39:8] entry_value
   output logic [1:0]  rsp_tuser,   // [0] is_new, [1] overflow
   // configuration
   input  logic        csr_we,
   input  logic        csr_wdata    // byte_swap
);

   localparam int CAP = (PALETTE_DEPTH < INDEX_SPAN) ? PALETTE_DEPTH : INDEX_SPAN;
   localparam int PW  = $clog2(CAP + 1);
   localparam int IW  = $clog2(CAP);

   logic             swap_ff;
   logic             busy_ff, busy_in;
   logic [IW-1:0]    pos_ff, pos_in;
   logic [PW-1:0]    used_ff, used_in;
   logic [PIX_W-1:0] pix_ff;
   logic             req_xfer;
   logic             rsp_xfer;

   token_type        tok_chain [0:CAP];
   logic [CAP-1:0]   hit_vec;
   logic [PIX_W-1:0] entry0;
   logic             hit;
   logic             fill;
   logic             ovf;
   logic             done;
   result_type       res;
   logic [PIX_W-1:0] res_word;

   logic             o0v_ff, o0v_in;
   logic             o1v_ff, o1v_in;
   result_type       o0_ff, o0_in;
   result_type       o1_ff, o1_in;

   assign req_tready = !busy_ff && !o1v_ff;
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         swap_ff <= 1'b0;
      end else if (csr_we) begin
         swap_ff <= csr_wdata;
      end
   end

   // chain of palette cells
   assign tok_chain[0].valid = req_xfer;
   assign tok_chain[0].pix   = req_tdata;

   for (genvar k = 0; k < CAP; k++) begin : g_cell
      if (k == 0) begin : g_head
         tcpi_cell #(.K(k), .PW(PW)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_i   (tok_chain[k]),
            .used_i  (used_ff),
            .tok_o   (tok_chain[k+1]),
            .hit_o   (hit_vec[k]),
            .entry_o (entry0)
         );
      end else begin : g_body
         tcpi_cell #(.K(k), .PW(PW)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_i   (tok_chain[k]),
            .used_i  (used_ff),
            .tok_o   (tok_chain[k+1]),
            .hit_o   (hit_vec[k]),
            .entry_o ()
         );
      end
   end

   // outcome of the current walk step
   assign hit  = |hit_vec;
   assign fill = busy_ff && (PW'(pos_ff) == used_ff);
   assign ovf  = tok_chain[CAP].valid;   // token fell off the last cell
   assign done = hit || fill || ovf;

   assign res_word   = ovf ? entry0 : pix_ff;
   assign res.idx    = ovf ? '0 : IDX_W'(pos_ff);
   assign res.is_new = fill;
   assign res.ovf    = ovf;
   assign res.word   = swap_ff ? swap_byte_order(res_word) : res_word;

   // walk control and fill count
   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      used_in = used_ff;
      if (req_xfer) begin
         busy_in = 1'b1;
         pos_in  = '0;
         if (req_tuser) begin
            used_in = '0;
         end
      end else if (busy_ff) begin
         pos_in = IW'(pos_ff + 1'b1);
         if (done) begin
            busy_in = 1'b0;
         end
         if (fill) begin
            used_in = PW'(used_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= '0;
         used_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
         used_ff <= used_in;
      end
      if (req_xfer) begin
         pix_ff <= req_tdata;
      end
   end

   // output stage plus skid register
   always_comb begin
      o0v_in = o0v_ff;
      o1v_in = o1v_ff;
      o0_in  = o0_ff;
      o1_in  = o1_ff;
      if (!o0v_ff || rsp_xfer) begin
         if (o1v_ff) begin
            o0_in  = o1_ff;
            o0v_in = 1'b1;
            o1_in  = res;
            o1v_in = done;
         end else begin
            o0_in  = res;
            o0v_in = done;
         end
      end else if (done) begin
         o1_in  = res;
         o1v_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o0v_ff <= 1'b0;
         o1v_ff <= 1'b0;
      end else begin
         o0v_ff <= o0v_in;
         o1v_ff <= o1v_in;
      end
      o0_ff <= o0_in;
      o1_ff <= o1_in;
   end

   assign rsp_tvalid = o0v_ff;
   assign rsp_tdata  = {o0_ff.word, o0_ff.idx};
   assign rsp_tuser  = {o0_ff.ovf, o0_ff.is_new};

   // checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= PW'(CAP))
      else $error("fill count beyond palette capacity");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one palette cell claims a hit");

   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (PW'(pos_ff) <= used_ff))
      else $error("token walked past the fill point");

   a_start_walk: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (busy_ff && pos_ff == '0))
      else $error("accepted pixel did not start a walk at cell zero");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      done |-> busy_ff)
      else $error("result produced with no pixel in flight");

endmodule

// ===== dv/tb_true_color_palette_indexer.sv =====
// ----------------------------------------------------------------------------
// tb_true_color_palette_indexer - stream testbench for the palette indexer
// Drives pixel words with random first-of-image marks and random gaps,
// stalls the result side at random, and checks every result field against
// a palette built alongside the block. Covers hits, appends, full-palette
// overflow and both byte orders of the reported entry word.
// ----------------------------------------------------------------------------
module tb_true_color_palette_indexer;
   import tcpi_pkg::*;

   localparam int DEPTH      = 256;
   localparam int CAP        = (DEPTH < INDEX_SPAN) ? DEPTH : INDEX_SPAN;
   localparam int RAND_ITEMS = 750;
   localparam int IDLE_LIMIT = 2000;

   // palette mirror and queue of expected results
   class palette_scoreboard;
      logic [PIX_W-1:0] colors [CAP];
      int               fill_count = 0;
      bit               swap       = 1'b0;
      result_type       expected_q [$];
      int               errors     = 0;
      int               n_pixels   = 0;
      int               n_images   = 0;
      int               n_new      = 0;
      int               n_hits     = 0;
      int               n_ovf      = 0;
      int               top_index  = 0;
      int               n_swapped  = 0;

      // work out the result of one accepted pixel transfer
      function void note_pixel(logic [PIX_W-1:0] pix, bit first);
         result_type       r;
         int               k;
         int               idx;
         bit               hit;
         logic [PIX_W-1:0] w;
         if (first) begin
            fill_count = 0;
            n_images++;
         end
         hit = 1'b0;
         idx = 0;
         r   = '0;
         for (k = 0; k < fill_count; k++) begin
            if (!hit && colors[k] == pix) begin
               hit = 1'b1;
               idx = k;
            end
         end
         if (!hit) begin
            if (fill_count < CAP) begin
               idx = fill_count;
               colors[idx] = pix;
               fill_count++;
               r.is_new = 1'b1;
               n_new++;
            end else begin
               idx   = 0;
               r.ovf = 1'b1;
               n_ovf++;
            end
         end else begin
            n_hits++;
         end
         w = colors[idx];
         if (swap) begin
            w = {w[7:0], w[15:8], w[23:16], w[31:24]};
            n_swapped++;
         end
         r.idx  = idx[IDX_W-1:0];
         r.word = w;
         if (idx > top_index) top_index = idx;
         n_pixels++;
         expected_q.push_back(r);
      endfunction

      // compare one result transfer with the oldest expectation
      function void check_result(logic [39:0] data, logic [1:0] user);
         result_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result idx=%h word=%h user=%b", $time,
                     data[7:0], data[39:8], user);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         if (data[7:0] !== e.idx) begin
            $display("%0t: color_index expected %h actual %h", $time, e.idx, data[7:0]);
            errors++;
         end
         if (user[0] !== e.is_new) begin
            $display("%0t: is_new expected %b actual %b", $time, e.is_new, user[0]);
            errors++;
         end
         if (data[39:8] !== e.word) begin
            $display("%0t: entry_value expected %h actual %h", $time, e.word, data[39:8]);
            errors++;
         end
         if (user[1] !== e.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, e.ovf, user[1]);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_we     = 1'b0;
   logic        csr_wdata  = 1'b0;

   palette_scoreboard sb;
   int  idle_cycles = 0;
   int  items_sent  = 0;
   int  rx_stall    = 0;
   bit  quiet       = 1'b0;

   true_color_palette_indexer #(
      .PALETTE_DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // gap length: mostly none or short, now and then long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [31:0] random_pixel();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   // result side back-pressure
   initial begin
      forever begin
         @(posedge clock);
         if (rx_stall > 0) begin
            rsp_tready <= 1'b0;
            rx_stall--;
         end else begin
            rsp_tready <= 1'b1;
            rx_stall = gap_len();
         end
      end
   end

   // monitor both channels and count cycles without a transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_pixel(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      end
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   // one pixel transfer, after a random gap
   task automatic send_pixel(input logic [31:0] pix, input bit first);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      req_tuser  <= first;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // hold the sender until every expected result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_swap(input bit v);
      drain_results();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.swap = v;
   endtask

   // image drawn from a small pool of colors, with some stray pixels,
   // restarts in the middle and sender pauses
   task automatic run_pool_image(input int pool_n, input int len);
      logic [31:0] pool [$];
      logic [31:0] pix;
      bit          first;
      int          i;
      int          r;
      for (i = 0; i < pool_n; i++) pool.push_back(random_pixel());
      for (i = 0; i < len; i++) begin
         r     = $urandom_range(0, 99);
         pix   = pool[$urandom_range(0, pool_n - 1)];
         first = (i == 0);
         if (r < 4) pix = random_pixel();
         else if (r < 7) first = 1'b1;
         else if (r < 9) drain_results();
         send_pixel(pix, first);
      end
   endtask

   // fill every entry, then mix misses on a full palette with hits
   task automatic run_full_image(input int extra);
      logic [31:0] mask;
      int          i;
      mask = $urandom;
      for (i = 0; i < CAP; i++) send_pixel(mask ^ i, i == 0);
      send_pixel(mask ^ (2 * CAP), 1'b0);
      for (i = 0; i < extra; i++) begin
         case ($urandom_range(0, 3))
            0:       send_pixel(mask ^ (CAP + i), 1'b0);
            1:       send_pixel(mask ^ (CAP - 1), 1'b0);
            2:       send_pixel(mask, 1'b0);
            default: send_pixel(mask ^ $urandom_range(0, CAP - 1), 1'b0);
         endcase
      end
   endtask

   initial begin
      int phase;
      int base;
      int n;
      sb = new;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stream without a first mark, extremes, hits, restarts
      quiet = 1'b1;
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'h8000_0001, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      quiet = 1'b0;
      send_pixel(32'h1234_5678, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      send_pixel(32'h1234_5678, 1'b1);
      send_pixel(32'h1234_5678, 1'b0);
      send_pixel(32'hA5A5_A5A5, 1'b0);
      send_pixel(32'h5A5A_5A5A, 1'b0);
      send_pixel(32'h0000_0001, 1'b0);
      send_pixel(32'h8000_0000, 1'b0);
      // byte-reversed entry words
      write_swap(1'b1);
      send_pixel(32'h0102_0304, 1'b1);
      send_pixel(32'hDEAD_BEEF, 1'b0);
      send_pixel(32'h0102_0304, 1'b0);
      send_pixel(32'hFFFF_0000, 1'b0);
      send_pixel(32'h0000_0000, 1'b1);

      // random images, byte order alternating per phase
      base  = items_sent;
      phase = 0;
      while (items_sent - base < RAND_ITEMS) begin
         write_swap(phase % 2 == 0);
         quiet = ($urandom_range(0, 3) == 0);
         if (phase < 2) run_full_image($urandom_range(20, 30));
         repeat (4) begin
            if (items_sent - base < RAND_ITEMS) begin
               quiet = ($urandom_range(0, 4) == 0);
               if ($urandom_range(0, 99) < 75) begin
                  n = $urandom_range(1, 12);
                  run_pool_image(n, $urandom_range(4, 40));
               end else begin
                  n = $urandom_range(16, 80);
                  run_pool_image(n, $urandom_range(30, 100));
               end
            end
         end
         phase++;
      end

      // let the last results come out
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (CAP + 4) @(posedge clock);

      $display("Covered %0d pixels in %0d images: %0d appends, %0d hits, %0d overflows",
               sb.n_pixels, sb.n_images, sb.n_new, sb.n_hits, sb.n_ovf);
      $display("Highest index %0d, %0d results with byte-reversed entry words",
               sb.top_index, sb.n_swapped);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== true_color_palette_indexer.f =====
rtl/core/tcpi_pkg.sv
rtl/core/tcpi_cell.sv
rtl/core/true_color_palette_indexer.sv
dv/tb_true_color_palette_indexer.sv
